// File: sv/stl_pkg.sv
// shared constants, codes and control structs for the segment time lookup
// no dependencies; used by every other file of the block
package stl_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int BLEND_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DUR_W      = 32;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = TIME_W - 1;
    localparam int BLEND_W    = BLEND_BITS + 1;
    localparam int STEP_W     = $clog2(BLEND_W);
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [BLEND_W-1:0] BLEND_ONE = {1'b1, {BLEND_BITS{1'b0}}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR,
        FUNC_APPEND,
        FUNC_QUERY,
        FUNC_NONE
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_EMPTY,
        STAT_FULL,
        STAT_CLEARED
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [DUR_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } tbl_req_t;

    typedef struct packed {
        logic             start;
        logic [DUR_W-1:0] num;
        logic [DUR_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [BLEND_W-1:0] quot;
    } div_rsp_t;

endpackage

// File: sv/stl_channels.sv
// valid/ready channel interfaces for command beats and result beats
// depends on stl_pkg for field widths
interface stl_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [stl_pkg::FUNC_W-1:0]    func;
    logic [stl_pkg::DUR_W-1:0]     segment_duration;
    logic signed [stl_pkg::TIME_W-1:0] request_time;

    modport source (output valid, output func, output segment_duration,
                    output request_time, input ready);
    modport sink   (input valid, input func, input segment_duration,
                    input request_time, output ready);
endinterface

interface stl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [stl_pkg::IDX_W-1:0]       index_before;
    logic [stl_pkg::IDX_W-1:0]       index_after;
    logic [stl_pkg::BLEND_W-1:0]     blend_fraction;
    logic [stl_pkg::STATUS_W-1:0]    status;
    logic [stl_pkg::CNT_W-1:0]       point_count;

    modport source (output valid, output index_before, output index_after,
                    output blend_fraction, output status, output point_count,
                    input ready);
    modport sink   (input valid, input index_before, input index_after,
                    input blend_fraction, input status, input point_count,
                    output ready);
endinterface

// File: sv/stl_table.sv
// duration table: single-port-write, single-port-read synchronous memory
// depends on stl_pkg; read data is registered and appears in the cycle after the address
module stl_table (
    input  logic                      clk,
    input  stl_pkg::tbl_req_t         req,
    output logic [stl_pkg::DUR_W-1:0] rdata
);
    import stl_pkg::*;

    logic [DUR_W-1:0] mem [MAX_POINTS];
    logic [DUR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/stl_divider.sv
// restoring divider for the blend fraction, one quotient bit per cycle
// depends on stl_pkg; numerator must not exceed the denominator
module stl_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  stl_pkg::div_req_t req,
    output stl_pkg::div_rsp_t rsp
);
    import stl_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DUR_W:0]     rem_reg, rem_next;
    logic [DUR_W-1:0]   den_reg, den_next;
    logic [BLEND_W-1:0] quot_reg, quot_next;

    logic [DUR_W:0] cand;
    logic [DUR_W:0] diff;
    logic           ge;

    always_comb
    begin
        cand = (step_reg == '0) ? rem_reg : {rem_reg[DUR_W-1:0], 1'b0};
        ge   = cand >= {1'b0, den_reg};
        diff = cand - {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {1'b0, req.num};
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff : cand;
            quot_next = {quot_reg[BLEND_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(BLEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// File: sv/segment_time_lookup.sv
// Segment time lookup: keeps up to 1024 waypoint durations in an on-chip table and answers
// time queries with the bracketing waypoint indices and a Q1.16 blend fraction. One item is
// handled at a time; a new command beat is taken once the block is idle and its result slot
// is free or draining. Clear, append and trivial queries are answered from the idle state. A
// query that walks the table reads one stored duration per cycle through the table's single
// read port until it reaches its segment, and then hands off the result. A time that falls
// inside a segment first passes through the serial divider and waits for its done beat.
// No clearing pass is needed after reset; the stored count bounds every read whose data is used.
// depends on stl_pkg, stl_channels, stl_table and stl_divider
module segment_time_lookup (
    input  logic      clk,
    input  logic      rst_n,
    stl_cmd_if.sink   cmd,
    stl_rsp_if.source rsp
);
    import stl_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   time_reg, time_next;
    logic [IDX_W-1:0]   before_reg, before_next;
    logic [IDX_W-1:0]   after_reg, after_next;
    logic [BLEND_W-1:0] blend_reg, blend_next;

    logic               ovalid_reg, ovalid_next;
    logic [IDX_W-1:0]   obefore_reg, obefore_next;
    logic [IDX_W-1:0]   oafter_reg, oafter_next;
    logic [BLEND_W-1:0] oblend_reg, oblend_next;
    status_t            ostatus_reg, ostatus_next;
    logic [CNT_W-1:0]   ocount_reg, ocount_next;

    tbl_req_t         tbl_req;
    logic [DUR_W-1:0] tbl_rdata;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic         slot_free;
    logic         in_fire;
    func_t        fn;
    logic         count_zero;
    logic         table_full;
    logic         time_neg;
    logic [SUM_W+1:0] sum_new;
    logic         reached;
    logic         last;

    stl_table u_table (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    stl_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign slot_free  = !ovalid_reg || rsp.ready;
    assign cmd.ready  = (state_reg == ST_IDLE) && slot_free;
    assign in_fire    = cmd.valid && cmd.ready;
    assign fn         = func_t'(cmd.func);
    assign count_zero = count_reg == '0;
    assign table_full = count_reg >= CNT_W'(MAX_POINTS);
    assign time_neg   = cmd.request_time[TIME_W-1];
    assign sum_new    = {2'b0, sum_reg} + {1'b0, tbl_rdata};
    assign reached    = sum_new >= {2'b0, time_reg};
    assign last       = {1'b0, k_reg} == (count_reg - CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && fn == FUNC_QUERY && !count_zero && !time_neg)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (reached && k_reg != '0)
                begin
                    state_next = ST_DIV;
                end
                else if (reached || last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next   = count_reg;
        k_next       = k_reg;
        sum_next     = sum_reg;
        time_next    = time_reg;
        before_next  = before_reg;
        after_next   = after_reg;
        blend_next   = blend_reg;
        ovalid_next  = ovalid_reg && !rsp.ready;
        obefore_next = obefore_reg;
        oafter_next  = oafter_reg;
        oblend_next  = oblend_reg;
        ostatus_next = ostatus_reg;
        ocount_next  = ocount_reg;

        tbl_req.we    = 1'b0;
        tbl_req.waddr = count_reg[IDX_W-1:0];
        tbl_req.wdata = cmd.segment_duration;
        tbl_req.raddr = (state_reg == ST_WALK) ? k_reg + IDX_W'(1) : '0;

        div_req.start = 1'b0;
        div_req.num   = {1'b0, time_reg - sum_reg};
        div_req.den   = tbl_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    obefore_next = '0;
                    oafter_next  = '0;
                    oblend_next  = '0;
                    ostatus_next = STAT_OK;
                    ovalid_next  = 1'b1;
                    k_next       = '0;
                    sum_next     = '0;
                    time_next    = cmd.request_time[SUM_W-1:0];
                    case (fn)
                        FUNC_CLEAR:
                        begin
                            count_next   = '0;
                            ostatus_next = STAT_CLEARED;
                        end
                        FUNC_APPEND:
                        begin
                            if (table_full)
                            begin
                                ostatus_next = STAT_FULL;
                            end
                            else
                            begin
                                tbl_req.we = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (count_zero)
                            begin
                                ostatus_next = STAT_EMPTY;
                            end
                            else if (!time_neg)
                            begin
                                ovalid_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    ocount_next = count_next;
                end
            end
            ST_WALK:
            begin
                if (reached)
                begin
                    if (k_reg == '0)
                    begin
                        before_next = '0;
                        after_next  = '0;
                        blend_next  = BLEND_ONE;
                    end
                    else
                    begin
                        before_next   = k_reg - IDX_W'(1);
                        after_next    = k_reg;
                        div_req.start = 1'b1;
                    end
                end
                else if (last)
                begin
                    before_next = k_reg;
                    after_next  = k_reg;
                    blend_next  = BLEND_ONE;
                end
                else
                begin
                    k_next   = k_reg + IDX_W'(1);
                    sum_next = sum_new[SUM_W-1:0];
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    blend_next = div_rsp.quot;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    ovalid_next  = 1'b1;
                    obefore_next = before_reg;
                    oafter_next  = after_reg;
                    oblend_next  = blend_reg;
                    ostatus_next = STAT_OK;
                    ocount_next  = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        sum_reg     <= sum_next;
        time_reg    <= time_next;
        before_reg  <= before_next;
        after_reg   <= after_next;
        blend_reg   <= blend_next;
        obefore_reg <= obefore_next;
        oafter_reg  <= oafter_next;
        oblend_reg  <= oblend_next;
        ostatus_reg <= ostatus_next;
        ocount_reg  <= ocount_next;
    end

    assign rsp.valid          = ovalid_reg;
    assign rsp.index_before   = obefore_reg;
    assign rsp.index_after    = oafter_reg;
    assign rsp.blend_fraction = oblend_reg;
    assign rsp.status         = ostatus_reg;
    assign rsp.point_count    = ocount_reg;

endmodule

// File: sv/stl_checker.sv
// port-level checks for segment_time_lookup, attached by bind
// depends on stl_pkg and on the top level's channel ports
module stl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [stl_pkg::IDX_W-1:0]    index_before,
    input logic [stl_pkg::IDX_W-1:0]    index_after,
    input logic [stl_pkg::BLEND_W-1:0]  blend_fraction,
    input logic [stl_pkg::STATUS_W-1:0] status,
    input logic [stl_pkg::CNT_W-1:0]    point_count
);
    import stl_pkg::*;

    logic [1:0] pending_reg, pending_next;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + {1'b0, in_fire} - {1'b0, out_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(index_before)
            && $stable(index_after) && $stable(blend_fraction)
            && $stable(status) && $stable(point_count))
        else $error("result beat changed while stalled");

    // one item in flight at most, and a result only for an accepted item
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd2 && pending_reg != 2'd3 && (!out_valid || pending_reg == 2'd1))
        else $error("command and result beats out of step");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_CLEARED || status == STAT_EMPTY) |-> point_count == '0)
        else $error("nonzero count after clear or on empty table");

    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> index_before <= index_after && blend_fraction <= BLEND_ONE
            && {1'b0, index_after} <= point_count)
        else $error("result indices or blend out of range");

endmodule

bind segment_time_lookup stl_checker u_stl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (cmd.valid),
    .in_ready       (cmd.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .index_before   (rsp.index_before),
    .index_after    (rsp.index_after),
    .blend_fraction (rsp.blend_fraction),
    .status         (rsp.status),
    .point_count    (rsp.point_count)
);
